@@ rtl/core/otbs_pkg.sv @@
// Shared types, constants and codes for the offset trim bracket search unit.
package otbs_pkg;

    localparam int AXES        = 6;
    localparam int AXIS_W      = 3;
    localparam int VAL_W       = 16;
    localparam int SUM_W       = 31;
    localparam int WINDOW_BITS = 14;
    localparam int EXPAND_STEP = 1000;
    localparam int NARROW_SPAN = 10;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_BISECT = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_AZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW      = 3'd7;

    localparam logic [VAL_W-1:0]       TARGET_AZ_RESET = 16'd16384;
    localparam logic [WINDOW_BITS-1:0] FAST_RESET      = 14'd1000;
    localparam logic [WINDOW_BITS-1:0] SLOW_RESET      = 14'd10000;

    typedef struct packed {
        logic              start;
        logic              accum;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              update;
        logic              round;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic phase_done;
        logic div_last;
    } sts_t;

    typedef logic signed [VAL_W-1:0] val_t;

endpackage

@@ rtl/core/otbs_dpath.sv @@
// Datapath: configuration, bracket state, window sums, shared divider and output register.
module otbs_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  otbs_pkg::cmd_t                       cmd,
    output otbs_pkg::sts_t                       sts,
    input  logic                                 cfg_we,
    input  logic [otbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [otbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  otbs_pkg::val_t [otbs_pkg::AXES-1:0]  sample,
    output otbs_pkg::val_t [otbs_pkg::AXES-1:0]  out_off,
    output logic [1:0]                           out_phase
);

    localparam int AX = otbs_pkg::AXES;
    localparam int WB = otbs_pkg::WINDOW_BITS;

    function automatic otbs_pkg::val_t sat16(input logic signed [17:0] v);
        logic signed [17:0] lim_hi;
        logic signed [17:0] lim_lo;
        lim_hi = 18'sd32767;
        lim_lo = -18'sd32768;
        if (v > lim_hi)
            return 16'sh7fff;
        else if (v < lim_lo)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Configuration registers.
    otbs_pkg::val_t          target_reg [AX];
    logic [WB-1:0]           fast_reg, fast_next;
    logic [WB-1:0]           slow_reg, slow_next;
    otbs_pkg::val_t          target_next [AX];

    // Search state.
    otbs_pkg::val_t          lo_reg [AX], lo_next [AX];
    otbs_pkg::val_t          hi_reg [AX], hi_next [AX];
    otbs_pkg::val_t          pend_reg [AX], pend_next [AX];
    otbs_pkg::val_t          probe_reg [AX], probe_next [AX];
    logic signed [otbs_pkg::SUM_W-1:0] sum_reg [AX], sum_next [AX];
    logic [WB-1:0]           cnt_reg, cnt_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    slow_mode_reg, slow_mode_next;
    logic                    narrow_reg, narrow_next;
    logic                    working_reg, working_next;
    logic                    expdone_reg, expdone_next;
    logic                    round_reg, round_next;
    logic [AX-1:0]           ge_reg, ge_next;
    logic [AX-1:0]           le_reg, le_next;

    // Divider.
    logic [WB-1:0]           rem_reg, rem_next;
    logic [otbs_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic                    neg_reg, neg_next;
    logic [otbs_pkg::DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    // Staged result and output register.
    otbs_pkg::val_t          res_reg [AX], res_next [AX];
    logic [1:0]              res_ph_reg, res_ph_next;
    otbs_pkg::val_t          out_reg [AX], out_next [AX];
    logic [1:0]              out_ph_reg, out_ph_next;

    logic [WB-1:0]           win_raw, win_len, cnt_inc;
    logic signed [otbs_pkg::DIV_W-1:0] dvd;
    logic [WB:0]             rem_sh;
    logic                    q_bit;
    otbs_pkg::val_t          avg;

    assign win_raw = slow_mode_reg ? slow_reg : fast_reg;
    assign win_len = (win_raw == '0) ? WB'(1) : win_raw;
    assign cnt_inc = cnt_reg + WB'(1);

    assign dvd    = otbs_pkg::DIV_W'(sum_reg[cmd.axis])
                  + otbs_pkg::DIV_W'({1'b0, win_len[WB-1:1]});
    assign rem_sh = {rem_reg, quo_reg[otbs_pkg::DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, win_len});

    always_comb
    begin
        if (!neg_reg)
            avg = (quo_reg > otbs_pkg::DIV_W'(32767)) ? 16'sh7fff : quo_reg[15:0];
        else
            avg = (quo_reg > otbs_pkg::DIV_W'(32768)) ? 16'sh8000
                                                       : 16'(-quo_reg);
    end

    assign sts.close      = (cnt_inc == '0) || (cnt_inc >= win_len);
    assign sts.phase_done = (phase_reg == otbs_pkg::PH_DONE);
    assign sts.div_last   = (dcnt_reg == '1);

    always_comb
    begin
        logic               any_ge;
        logic               any_le;
        logic               all_nar;
        logic               any_wk;
        logic signed [17:0] diff;
        logic signed [16:0] mid_sum;
        any_ge = 1'b0;
        any_le = 1'b0;
        all_nar = 1'b1;
        any_wk = 1'b0;
        diff = '0;
        mid_sum = '0;

        fast_next = fast_reg;
        slow_next = slow_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        slow_mode_next = slow_mode_reg;
        narrow_next = narrow_reg;
        working_next = working_reg;
        expdone_next = expdone_reg;
        round_next = round_reg;
        ge_next = ge_reg;
        le_next = le_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        dcnt_next = dcnt_reg;
        res_ph_next = res_ph_reg;
        out_ph_next = out_ph_reg;
        for (int i = 0; i < AX; i++)
        begin
            target_next[i] = target_reg[i];
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
            pend_next[i] = pend_reg[i];
            probe_next[i] = probe_reg[i];
            sum_next[i] = sum_reg[i];
            res_next[i] = res_reg[i];
            out_next[i] = out_reg[i];
        end

        if (cfg_we)
        begin
            case (cfg_index)
                otbs_pkg::REG_FAST: fast_next = cfg_wdata[WB-1:0];
                otbs_pkg::REG_SLOW: slow_next = cfg_wdata[WB-1:0];
                default:            target_next[cfg_index] = cfg_wdata;
            endcase
        end

        if (cmd.start)
        begin
            for (int i = 0; i < AX; i++)
            begin
                lo_next[i] = '0;
                hi_next[i] = '0;
                pend_next[i] = '0;
                probe_next[i] = '0;
                sum_next[i] = '0;
                res_next[i] = '0;
            end
            cnt_next = '0;
            slow_mode_next = 1'b0;
            narrow_next = 1'b0;
            working_next = 1'b0;
            expdone_next = 1'b1;
            round_next = 1'b0;
            phase_next = otbs_pkg::PH_LOW;
            res_ph_next = otbs_pkg::PH_LOW;
        end

        if (cmd.accum)
        begin
            for (int i = 0; i < AX; i++)
                sum_next[i] = sum_reg[i] + otbs_pkg::SUM_W'(sample[i]);
            cnt_next = cnt_inc;
        end

        if (cmd.div_load)
        begin
            neg_next = dvd[otbs_pkg::DIV_W-1];
            quo_next = dvd[otbs_pkg::DIV_W-1] ? otbs_pkg::DIV_W'(-dvd) : dvd;
            rem_next = '0;
            dcnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = q_bit ? WB'(rem_sh - {1'b0, win_len}) : rem_sh[WB-1:0];
            quo_next = {quo_reg[otbs_pkg::DIV_W-2:0], q_bit};
            dcnt_next = dcnt_reg + otbs_pkg::DIV_CNT_W'(1);
        end

        if (cmd.div_store)
        begin
            ge_next[cmd.axis] = (avg >= target_reg[cmd.axis]);
            le_next[cmd.axis] = (avg <= target_reg[cmd.axis]);
        end

        if (cmd.update)
        begin
            for (int i = 0; i < AX; i++)
                sum_next[i] = '0;
            cnt_next = '0;
            round_next = 1'b0;
            case (phase_reg)
                otbs_pkg::PH_LOW:
                begin
                    for (int i = 0; i < AX; i++)
                    begin
                        if (ge_reg[i])
                        begin
                            any_ge = 1'b1;
                            pend_next[i] = sat16(18'(lo_reg[i]) - 18'(otbs_pkg::EXPAND_STEP));
                        end
                        else
                            pend_next[i] = lo_reg[i];
                        res_next[i] = hi_reg[i];
                    end
                    if (any_ge)
                        expdone_next = 1'b0;
                    phase_next = otbs_pkg::PH_HIGH;
                    res_ph_next = otbs_pkg::PH_HIGH;
                end
                otbs_pkg::PH_HIGH:
                begin
                    for (int i = 0; i < AX; i++)
                    begin
                        if (le_reg[i])
                        begin
                            any_le = 1'b1;
                            hi_next[i] = sat16(18'(hi_reg[i]) + 18'(otbs_pkg::EXPAND_STEP));
                        end
                        lo_next[i] = pend_reg[i];
                        res_next[i] = pend_reg[i];
                    end
                    if (expdone_reg && !any_le)
                    begin
                        narrow_next = 1'b0;
                        round_next = 1'b1;
                    end
                    else
                    begin
                        expdone_next = 1'b1;
                        phase_next = otbs_pkg::PH_LOW;
                        res_ph_next = otbs_pkg::PH_LOW;
                    end
                end
                otbs_pkg::PH_BISECT:
                begin
                    for (int i = 0; i < AX; i++)
                    begin
                        if (!le_reg[i])
                            hi_next[i] = probe_reg[i];
                        else
                            lo_next[i] = probe_reg[i];
                        res_next[i] = lo_next[i];
                    end
                    if (working_reg)
                        round_next = 1'b1;
                    else
                    begin
                        phase_next = otbs_pkg::PH_DONE;
                        res_ph_next = otbs_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.round && round_reg)
        begin
            if (narrow_reg && !slow_mode_reg)
                slow_mode_next = 1'b1;
            for (int i = 0; i < AX; i++)
            begin
                diff = 18'(hi_reg[i]) - 18'(lo_reg[i]);
                mid_sum = 17'(hi_reg[i]) + 17'(lo_reg[i]);
                if (diff <= 18'sd1)
                    probe_next[i] = lo_reg[i];
                else
                begin
                    any_wk = 1'b1;
                    probe_next[i] = 16'((mid_sum + 17'(mid_sum[16] & mid_sum[0])) >>> 1);
                    if (diff > 18'(otbs_pkg::NARROW_SPAN))
                        all_nar = 1'b0;
                end
                res_next[i] = probe_next[i];
            end
            narrow_next = all_nar;
            working_next = any_wk;
            phase_next = otbs_pkg::PH_BISECT;
            res_ph_next = otbs_pkg::PH_BISECT;
        end

        if (cmd.load_out)
        begin
            for (int i = 0; i < AX; i++)
                out_next[i] = res_reg[i];
            out_ph_next = res_ph_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AX; i++)
                target_reg[i] <= (i == int'(otbs_pkg::REG_TARGET_AZ))
                               ? otbs_pkg::TARGET_AZ_RESET : '0;
            fast_reg <= otbs_pkg::FAST_RESET;
            slow_reg <= otbs_pkg::SLOW_RESET;
            cnt_reg <= '0;
            phase_reg <= otbs_pkg::PH_DONE;
            slow_mode_reg <= 1'b0;
            narrow_reg <= 1'b0;
            working_reg <= 1'b0;
            expdone_reg <= 1'b1;
            round_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < AX; i++)
                target_reg[i] <= target_next[i];
            fast_reg <= fast_next;
            slow_reg <= slow_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            slow_mode_reg <= slow_mode_next;
            narrow_reg <= narrow_next;
            working_reg <= working_next;
            expdone_reg <= expdone_next;
            round_reg <= round_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AX; i++)
        begin
            lo_reg[i] <= lo_next[i];
            hi_reg[i] <= hi_next[i];
            pend_reg[i] <= pend_next[i];
            probe_reg[i] <= probe_next[i];
            sum_reg[i] <= sum_next[i];
            res_reg[i] <= res_next[i];
            out_reg[i] <= out_next[i];
        end
        ge_reg <= ge_next;
        le_reg <= le_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        res_ph_reg <= res_ph_next;
        out_ph_reg <= out_ph_next;
    end

    always_comb
    begin
        for (int i = 0; i < AX; i++)
            out_off[i] = out_reg[i];
    end
    assign out_phase = out_ph_reg;

endmodule

@@ rtl/core/otbs_ctrl.sv @@
// Controller: request sequencing, per-axis divide loop and output handshake.
module otbs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    output logic            out_valid,
    input  logic            out_ready,
    input  otbs_pkg::sts_t  sts,
    output otbs_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_RUN   = 7'b0000100,
        S_STORE = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [otbs_pkg::AXIS_W-1:0]   axis_reg, axis_next;
    logic                          oval_reg, oval_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        oval_next = oval_reg && !out_ready;
        cmd = '0;
        cmd.axis = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!kind)
                    begin
                        cmd.start = 1'b1;
                        state_next = S_EMIT;
                    end
                    else if (!sts.phase_done)
                    begin
                        cmd.accum = 1'b1;
                        if (sts.close)
                        begin
                            axis_next = '0;
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (axis_reg == otbs_pkg::AXIS_W'(otbs_pkg::AXES - 1))
                    state_next = S_UPD;
                else
                begin
                    axis_next = axis_reg + otbs_pkg::AXIS_W'(1);
                    state_next = S_LOAD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!oval_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    oval_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            oval_reg <= oval_next;
        end
    end

    // The output register is only reloaded once its previous request has left.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!oval_reg || out_ready))
        else $error("output reloaded while a request still waits");

    // A quotient is stored only right after the last divide step.
    a_store_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> $past(cmd.div_step && sts.div_last))
        else $error("quotient stored before the divide finished");

    // Samples are summed only for an accepted request.
    a_accum_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> (in_valid && in_ready && kind))
        else $error("sample summed without an accepted request");

    // Closing a window always leads to the divide of the first axis.
    a_close_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accum && sts.close) |=> (cmd.div_load && cmd.axis == '0))
        else $error("closed window did not start the divide");

endmodule

@@ rtl/core/offset_trim_bracket_search_unit.sv @@
// Top level of the offset trim bracket search unit.
// This unit trims six sensor offsets by bracket search. A request with kind 0 starts a new
// search and is answered by one result with zero offsets and phase 0, which is staged and
// then loaded into the output register. A request with kind 1 carries one six-axis
// sample; it is summed into the current window and produces a result only when it closes
// the window, and it is ignored once the search is done. A request that does not close a
// window leaves the unit idle, so the next request can follow right away. A closing
// request is not through until its result is valid and the next request can be taken:
// each of the six window averages takes a load step, a divide in one shared restoring
// divider that produces one quotient bit per cycle, and a compare step, and these are
// followed by a bracket update, a midpoint computation and the load of the output
// register. The result waits in that register while the next request is accepted; a later
// result waits until the earlier one has been taken.
// Configuration registers (targets, fast and slow window lengths) are written through
// cfg_we, cfg_index and cfg_wdata and must only change while the unit is idle.
module offset_trim_bracket_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [otbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [otbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic signed [15:0]                 sample_ax,
    input  logic signed [15:0]                 sample_ay,
    input  logic signed [15:0]                 sample_az,
    input  logic signed [15:0]                 sample_gx,
    input  logic signed [15:0]                 sample_gy,
    input  logic signed [15:0]                 sample_gz,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [15:0]                 offset_ax,
    output logic signed [15:0]                 offset_ay,
    output logic signed [15:0]                 offset_az,
    output logic signed [15:0]                 offset_gx,
    output logic signed [15:0]                 offset_gy,
    output logic signed [15:0]                 offset_gz,
    output logic [1:0]                         phase
);

    otbs_pkg::cmd_t                           cmd;
    otbs_pkg::sts_t                           sts;
    otbs_pkg::val_t [otbs_pkg::AXES-1:0]      sample;
    otbs_pkg::val_t [otbs_pkg::AXES-1:0]      out_off;

    // Axis order matches the register order: accel x, y, z, then gyro x, y, z.
    assign sample = {sample_gz, sample_gy, sample_gx, sample_az, sample_ay, sample_ax};

    assign offset_ax = out_off[0];
    assign offset_ay = out_off[1];
    assign offset_az = out_off[2];
    assign offset_gx = out_off[3];
    assign offset_gy = out_off[4];
    assign offset_gz = out_off[5];

    // The controller sequences each request and the divide loop.
    otbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the brackets, window sums, divider and output register.
    otbs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample),
        .out_off   (out_off),
        .out_phase (phase)
    );

endmodule

@@ tb/tb_offset_trim_bracket_search_unit.sv @@
// Self-checking testbench for the offset trim bracket search unit.
module tb_offset_trim_bracket_search_unit;
    import otbs_pkg::*;

    // Register indexes that the package does not name.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_AY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GZ = 3'd5;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int ITEM_GOAL     = 400;

    // One request as it travels to the unit: kind and six raw readings.
    typedef struct packed {
        logic                  kind;
        logic [5:0][VAL_W-1:0] reading;
    } request_t;

    // One set of offsets with its search phase.
    typedef struct packed {
        logic [5:0][VAL_W-1:0] offs;
        logic [1:0]            ph;
    } trim_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = 1'b0;
    logic signed [15:0]    sample_ax = '0;
    logic signed [15:0]    sample_ay = '0;
    logic signed [15:0]    sample_az = '0;
    logic signed [15:0]    sample_gx = '0;
    logic signed [15:0]    sample_gy = '0;
    logic signed [15:0]    sample_gz = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    offset_ax;
    logic signed [15:0]    offset_ay;
    logic signed [15:0]    offset_az;
    logic signed [15:0]    offset_gx;
    logic signed [15:0]    offset_gy;
    logic signed [15:0]    offset_gz;
    logic [1:0]            phase;

    offset_trim_bracket_search_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .sample_ax(sample_ax), .sample_ay(sample_ay), .sample_az(sample_az),
        .sample_gx(sample_gx), .sample_gy(sample_gy), .sample_gz(sample_gz),
        .out_valid(out_valid), .out_ready(out_ready),
        .offset_ax(offset_ax), .offset_ay(offset_ay), .offset_az(offset_az),
        .offset_gx(offset_gx), .offset_gy(offset_gy), .offset_gz(offset_gz),
        .phase(phase)
    );

    // Requests waiting for the driver and offsets waiting for the unit.
    request_t request_q[$];
    trim_t    trim_q[$];

    bit failed = 1'b0;
    int cycles = 0;
    int items_sent = 0;

    // Mirror of the unit's configuration and search state.
    int       target[6];
    int       fast_len;
    int       slow_len;
    int       low_b[6];
    int       high_b[6];
    int       next_low[6];
    int       probe[6];
    int       win_sum[6];
    int       win_count;
    logic [1:0] search_ph;
    bit       use_slow;
    bit       narrow_all;
    bit       any_open;
    bit       no_move;

    // Offsets of the latest predicted result, which the sensor emulation applies.
    int       applied[6];
    logic [1:0] applied_ph;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic trim_t pack_trim(int vals[6], logic [1:0] ph);
        trim_t t;
        for (int i = 0; i < 6; i++) t.offs[i] = vals[i][15:0];
        t.ph = ph;
        return t;
    endfunction

    // Opens the next bisect round: every open bracket is probed at its midpoint.
    task automatic open_bisect_round();
        if (narrow_all && !use_slow) use_slow = 1'b1;
        narrow_all = 1'b1;
        any_open = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (high_b[i] <= low_b[i] + 1) begin
                probe[i] = low_b[i];
            end else begin
                any_open = 1'b1;
                probe[i] = (low_b[i] + high_b[i]) / 2;
                if (high_b[i] > low_b[i] + NARROW_SPAN) narrow_all = 1'b0;
            end
        end
        search_ph = PH_BISECT;
    endtask

    // Advances the mirrored search by one request; got tells whether a result follows.
    task automatic search_step(input request_t r, output bit got, output trim_t res);
        int avg[6];
        int n;
        got = 1'b0;
        res = '0;
        if (r.kind == KIND_START) begin
            for (int i = 0; i < 6; i++) begin
                low_b[i] = 0; high_b[i] = 0; next_low[i] = 0; probe[i] = 0; win_sum[i] = 0;
            end
            win_count = 0;
            use_slow = 1'b0;
            narrow_all = 1'b0;
            any_open = 1'b0;
            no_move = 1'b1;
            search_ph = PH_LOW;
            got = 1'b1;
            res = pack_trim(low_b, PH_LOW);
            return;
        end
        // Samples after the search has finished are dropped.
        if (search_ph == PH_DONE) return;
        for (int i = 0; i < 6; i++) win_sum[i] += int'($signed(r.reading[i]));
        win_count = (win_count + 1) & 16'h3fff;
        n = use_slow ? slow_len : fast_len;
        if (n == 0) n = 1;
        if (win_count != 0 && win_count < n) return;
        // The window closes: rounded averages, clamped in case the window shrank.
        for (int i = 0; i < 6; i++) begin
            avg[i] = clamp16((longint'(win_sum[i]) + longint'(n / 2)) / longint'(n));
            win_sum[i] = 0;
        end
        win_count = 0;
        got = 1'b1;
        if (search_ph == PH_LOW) begin
            for (int i = 0; i < 6; i++) begin
                if (avg[i] >= target[i]) begin
                    no_move = 1'b0;
                    next_low[i] = clamp16(longint'(low_b[i]) - EXPAND_STEP);
                end else begin
                    next_low[i] = low_b[i];
                end
            end
            search_ph = PH_HIGH;
            res = pack_trim(high_b, PH_HIGH);
        end else if (search_ph == PH_HIGH) begin
            for (int i = 0; i < 6; i++) begin
                if (avg[i] <= target[i]) begin
                    no_move = 1'b0;
                    high_b[i] = clamp16(longint'(high_b[i]) + EXPAND_STEP);
                end
                low_b[i] = next_low[i];
            end
            if (no_move) begin
                // A full round moved no bound, so bisection takes over.
                narrow_all = 1'b0;
                open_bisect_round();
                res = pack_trim(probe, PH_BISECT);
            end else begin
                no_move = 1'b1;
                search_ph = PH_LOW;
                res = pack_trim(low_b, PH_LOW);
            end
        end else begin
            for (int i = 0; i < 6; i++) begin
                if (avg[i] > target[i]) high_b[i] = probe[i];
                else low_b[i] = probe[i];
            end
            if (any_open) begin
                open_bisect_round();
                res = pack_trim(probe, PH_BISECT);
            end else begin
                search_ph = PH_DONE;
                res = pack_trim(low_b, PH_DONE);
            end
        end
    endtask

    // Predicts the request, records the expected offsets and queues the request.
    task automatic send_request(input logic k, input int vals[6], output bit got);
        request_t r;
        trim_t    res;
        r.kind = k;
        for (int i = 0; i < 6; i++) r.reading[i] = vals[i][15:0];
        search_step(r, got, res);
        if (got) begin
            trim_q.push_back(res);
            for (int i = 0; i < 6; i++) applied[i] = int'($signed(res.offs[i]));
            applied_ph = res.ph;
        end
        request_q.push_back(r);
        items_sent++;
    endtask

    task automatic send_fill(input logic k, input logic [15:0] v);
        int vals[6];
        bit got;
        for (int i = 0; i < 6; i++) vals[i] = int'($signed(v));
        send_request(k, vals, got);
    endtask

    task automatic send_noise();
        int vals[6];
        bit got;
        for (int i = 0; i < 6; i++) vals[i] = int'($signed(16'($urandom())));
        send_request(KIND_SAMPLE, vals, got);
    endtask

    // Waits until the unit has taken every request and returned every result.
    task automatic wait_idle();
        while (request_q.size() != 0 || in_valid || trim_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < 6) target[idx] = int'($signed(value[15:0]));
        else if (idx == REG_FAST) fast_len = value & 16'h3fff;
        else if (idx == REG_SLOW) slow_len = value & 16'h3fff;
    endtask

    // Emulated sensor: each reading is the bias plus the offset last applied plus noise.
    // A search runs until it finishes, the window budget is spent or enough requests went out.
    task automatic run_search(input int bias[6], input int max_windows, input int noise);
        int vals[6];
        bit got;
        int windows;
        send_fill(KIND_START, 16'h0000);
        windows = 0;
        while (applied_ph != PH_DONE && windows < max_windows && items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 30) == 0) send_noise();
            for (int i = 0; i < 6; i++)
                vals[i] = clamp16(longint'(bias[i]) + longint'(applied[i]) +
                                  longint'(int'($urandom_range(0, 2 * noise))) -
                                  longint'(noise));
            send_request(KIND_SAMPLE, vals, got);
            if (got) windows++;
        end
    endtask

    // Driver: once a request is taken, the next appears at a falling edge, after a random gap outside bursts.
    bit in_taken = 1'b0;
    int in_gap = 0;
    bit in_burst = 1'b0;
    always @(posedge clk) in_taken <= in_valid && in_ready;

    always @(negedge clk) begin
        request_t r;
        if (!in_valid || in_taken) begin
            if ($urandom_range(0, 40) == 0) in_burst = !in_burst;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                r = request_q.pop_front();
                kind <= r.kind;
                sample_ax <= r.reading[0];
                sample_ay <= r.reading[1];
                sample_az <= r.reading[2];
                sample_gx <= r.reading[3];
                sample_gy <= r.reading[4];
                sample_gz <= r.reading[5];
                in_valid <= 1'b1;
                in_gap = in_burst ? 0 : $urandom_range(0, 14);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: after a result is taken, out_ready may be held low for a random gap, but not in a burst.
    bit out_taken = 1'b0;
    int out_wait = 0;
    bit out_burst = 1'b0;
    always @(negedge clk) begin
        if (out_taken) begin
            if ($urandom_range(0, 20) == 0) out_burst = !out_burst;
            out_wait = out_burst ? 0 : $urandom_range(0, 14);
        end
        if (out_wait > 0) begin
            out_wait--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: every result taken is compared with the oldest expectation.
    always @(posedge clk) begin
        trim_t exp_trim;
        logic [15:0] got_off[6];
        string names[6];
        out_taken <= out_valid && out_ready;
        if (rst_n && out_valid && out_ready) begin
            names = '{"offset_ax", "offset_ay", "offset_az",
                      "offset_gx", "offset_gy", "offset_gz"};
            got_off = '{offset_ax, offset_ay, offset_az, offset_gx, offset_gy, offset_gz};
            if (trim_q.size() == 0) begin
                $error("result with no expectation waiting");
                failed = 1'b1;
            end else begin
                exp_trim = trim_q.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (got_off[i] !== exp_trim.offs[i]) begin
                        $error("%s expected %0d actual %0d", names[i],
                               $signed(exp_trim.offs[i]), $signed(got_off[i]));
                        failed = 1'b1;
                    end
                end
                if (phase !== exp_trim.ph) begin
                    $error("phase expected %0d actual %0d", exp_trim.ph, phase);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int bias[6];
        int vals[6];
        bit got;
        // Mirror of the reset state.
        for (int i = 0; i < 6; i++) begin
            target[i] = 0; low_b[i] = 0; high_b[i] = 0; next_low[i] = 0;
            probe[i] = 0; win_sum[i] = 0; applied[i] = 0;
        end
        target[2] = 16384;
        fast_len = 1000;
        slow_len = 10000;
        win_count = 0;
        search_ph = PH_DONE;
        use_slow = 1'b0;
        narrow_all = 1'b0;
        any_open = 1'b0;
        no_move = 1'b1;
        applied_ph = PH_DONE;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Samples before any start are dropped.
        send_fill(KIND_SAMPLE, 16'h7fff);
        send_fill(KIND_SAMPLE, 16'h8000);
        // A zero window length behaves as a window of one sample.
        write_reg(REG_FAST, 0);
        write_reg(REG_SLOW, 16383);
        write_reg(REG_TARGET_AX, 32767);
        write_reg(REG_TARGET_AY, -32768);
        send_fill(KIND_START, 16'h0000);
        send_fill(KIND_SAMPLE, 16'h7fff);
        send_fill(KIND_SAMPLE, 16'h8000);
        send_fill(KIND_SAMPLE, 16'h5555);
        send_fill(KIND_SAMPLE, 16'haaaa);
        send_fill(KIND_SAMPLE, 16'hffff);
        send_fill(KIND_SAMPLE, 16'h0000);
        // A start in the middle of a search aborts it.
        send_fill(KIND_START, 16'h0000);
        // Targets at the limits pin the bounds at saturation.
        for (int i = 0; i < 6; i++) bias[i] = 0;
        run_search(bias, 70, 0);

        // A window shortened while it is partly full closes on the next sample with a
        // clamped average.
        write_reg(REG_FAST, 16383);
        send_fill(KIND_START, 16'h0000);
        for (int k = 0; k < 8; k++) send_fill(KIND_SAMPLE, 16'h7fff);
        write_reg(REG_FAST, 2);
        send_fill(KIND_SAMPLE, 16'h7fff);
        write_reg(REG_FAST, 16383);
        for (int k = 0; k < 8; k++) send_fill(KIND_SAMPLE, 16'h8000);
        write_reg(REG_FAST, 1);
        send_fill(KIND_SAMPLE, 16'h8000);

        // Random part: complete searches under changing targets and window lengths.
        while (items_sent < ITEM_GOAL) begin
            write_reg(REG_TARGET_AX, $urandom_range(0, 20000) - 10000);
            write_reg(REG_TARGET_AY, $urandom_range(0, 20000) - 10000);
            write_reg(REG_TARGET_AZ, $urandom_range(0, 20000));
            write_reg(REG_TARGET_GX, $urandom_range(0, 20000) - 10000);
            write_reg(REG_TARGET_GY, $urandom_range(0, 20000) - 10000);
            write_reg(REG_TARGET_GZ, $urandom_range(0, 20000) - 10000);
            write_reg(REG_FAST, $urandom_range(0, 3));
            write_reg(REG_SLOW, $urandom_range(1, 4));
            for (int i = 0; i < 6; i++) bias[i] = $urandom_range(0, 16000) - 8000;
            if ($urandom_range(0, 3) == 0) send_noise();
            run_search(bias, $urandom_range(10, 60), $urandom_range(0, 3));
            // Sometimes one more sample after the run, which the unit ignores if the search is done.
            if ($urandom_range(0, 2) == 0) begin
                for (int i = 0; i < 6; i++) vals[i] = applied[i];
                send_request(KIND_SAMPLE, vals, got);
            end
        end

        wait_idle();
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ offset_trim_bracket_search_unit.f @@
rtl/core/otbs_pkg.sv
rtl/core/otbs_dpath.sv
rtl/core/otbs_ctrl.sv
rtl/core/offset_trim_bracket_search_unit.sv
tb/tb_offset_trim_bracket_search_unit.sv
